[rtl/core/bbd_pkg.sv]
// Package for the bounded byte deque: operation and status codes, the item
// structs of both channels, controller states and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_SEARCH     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] front_byte;
    logic [7:0] back_byte;
    logic [7:0] length;
    logic       is_empty;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_RDEND,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       load_op;
    logic       push_first;
    logic       push_last;
    logic       drop_first;
    logic       drop_last;
    logic       toggle_rev;
    logic       set_status;
    logic [1:0] status_code;
    logic       srch_start;
    logic       srch_step;
    logic       rd_ends;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       rev;
    logic       srch_done;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/bbd_datapath.sv]
// Datapath of the bounded byte deque: ring store, head, count, direction
// flag, search walker and result register. Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_datapath #(
  parameter int DEPTH = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bbd_pkg::in_t      in_i,
  input  wire bbd_pkg::cmd_t     cmd_i,
  output bbd_pkg::dp_stat_t      stat_o,
  output bbd_pkg::out_t          out_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_q [DEPTH];
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          rev_q, rev_d;
  logic [2:0]    op_q;
  logic [7:0]    value_q;
  logic [1:0]    status_q;
  logic          found_q, found_d;
  logic [CW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [7:0]    rd_a_q, rd_b_q;
  bbd_pkg::out_t out_q;

  logic [AW-1:0] head_inc, head_dec, wr_addr, rd_a_addr, rd_b_addr, last_k;
  logic          issue;
  logic          wr_en;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign last_k   = (count_q == '0) ? '0 : AW'(count_q - 1'b1);
  assign issue    = cmd_i.srch_step && (k_q < count_q) && !found_q;

  assign wr_en     = cmd_i.push_first || cmd_i.push_last;
  assign wr_addr   = cmd_i.push_first ? head_dec : wrap_add(head_q, count_q[AW-1:0]);
  assign rd_a_addr = cmd_i.srch_step ? wrap_add(head_q, k_q[AW-1:0]) : head_q;
  assign rd_b_addr = wrap_add(head_q, last_k);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rev_d   = rev_q;
    if (cmd_i.push_first) begin
      head_d  = head_dec;
      count_d = count_q + 1'b1;
    end else if (cmd_i.push_last) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.drop_first) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
    end else if (cmd_i.drop_last) begin
      count_d = count_q - 1'b1;
    end
    if (cmd_i.toggle_rev) begin
      rev_d = !rev_q;
    end
  end

  always_comb begin
    k_d     = k_q;
    pend_d  = pend_q;
    found_d = found_q;
    if (cmd_i.load_op || cmd_i.srch_start) begin
      k_d     = '0;
      pend_d  = 1'b0;
      found_d = 1'b0;
    end else if (cmd_i.srch_step) begin
      pend_d = issue;
      if (issue) begin
        k_d = k_q + 1'b1;
      end
      if (pend_q && (rd_a_q == value_q)) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
    if (cmd_i.rd_ends || cmd_i.srch_step) begin
      rd_a_q <= mem_q[rd_a_addr];
    end
    if (cmd_i.rd_ends) begin
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      op_q    <= in_i.operation;
      value_q <= in_i.value;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.out_load) begin
      out_q.status     <= status_q;
      out_q.found      <= found_q;
      out_q.front_byte <= (count_q == '0) ? 8'd0 : (rev_q ? rd_b_q : rd_a_q);
      out_q.back_byte  <= (count_q == '0) ? 8'd0 : (rev_q ? rd_a_q : rd_b_q);
      out_q.length     <= 8'(count_q);
      out_q.is_empty   <= (count_q == '0);
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.rev       = rev_q;
  assign stat_o.srch_done = found_q || (!(k_q < count_q) && !pend_q);
  assign out_o            = out_q;

endmodule

`default_nettype wire

[rtl/core/bbd_ctrl.sv]
// Controller of the bounded byte deque: sequences execute, search, end reads
// and result loading, and owns the output valid flag. Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire bbd_pkg::dp_stat_t stat_i,
  output bbd_pkg::cmd_t          cmd_o
);

  bbd_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            fin_go;

  assign fin_go = (state_q == bbd_pkg::S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bbd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = bbd_pkg::S_EXEC;
        end
      end
      bbd_pkg::S_EXEC: begin
        if ((stat_i.op == bbd_pkg::OP_SEARCH) && !stat_i.empty) begin
          state_d = bbd_pkg::S_SRCH;
        end else begin
          state_d = bbd_pkg::S_RDEND;
        end
      end
      bbd_pkg::S_SRCH: begin
        if (stat_i.srch_done) begin
          state_d = bbd_pkg::S_RDEND;
        end
      end
      bbd_pkg::S_RDEND: state_d = bbd_pkg::S_FIN;
      bbd_pkg::S_FIN: begin
        if (fin_go) begin
          state_d = bbd_pkg::S_IDLE;
        end
      end
      default: state_d = bbd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      bbd_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_op = in_valid_i;
      end
      bbd_pkg::S_EXEC: begin
        cmd_o.set_status  = 1'b1;
        cmd_o.status_code = bbd_pkg::ST_OK;
        case (stat_i.op) inside
          bbd_pkg::OP_PUSH_FRONT, bbd_pkg::OP_PUSH_BACK: begin
            if (stat_i.full) begin
              cmd_o.status_code = bbd_pkg::ST_FULL;
            end else if ((stat_i.op == bbd_pkg::OP_PUSH_FRONT) != stat_i.rev) begin
              cmd_o.push_first = 1'b1;
            end else begin
              cmd_o.push_last = 1'b1;
            end
          end
          bbd_pkg::OP_POP_FRONT, bbd_pkg::OP_POP_BACK: begin
            if (stat_i.empty) begin
              cmd_o.status_code = bbd_pkg::ST_EMPTY;
            end else if ((stat_i.op == bbd_pkg::OP_POP_FRONT) != stat_i.rev) begin
              cmd_o.drop_first = 1'b1;
            end else begin
              cmd_o.drop_last = 1'b1;
            end
          end
          bbd_pkg::OP_REVERSE: begin
            if (stat_i.empty) begin
              cmd_o.status_code = bbd_pkg::ST_EMPTY;
            end else begin
              cmd_o.toggle_rev = 1'b1;
            end
          end
          bbd_pkg::OP_SEARCH: begin
            if (stat_i.empty) begin
              cmd_o.status_code = bbd_pkg::ST_EMPTY;
            end else begin
              cmd_o.srch_start = 1'b1;
            end
          end
          default: cmd_o.status_code = bbd_pkg::ST_OK;
        endcase
      end
      bbd_pkg::S_SRCH:  cmd_o.srch_step = 1'b1;
      bbd_pkg::S_RDEND: cmd_o.rd_ends = 1'b1;
      bbd_pkg::S_FIN:   cmd_o.out_load = fin_go;
      default:          cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/bounded_byte_deque.sv]
// Bounded byte deque top level: joins the controller and the datapath.
// Depends on bbd_pkg, bbd_ctrl and bbd_datapath.
// Sequence: each accepted item passes the execute, end-read and result-load steps in
// order; a search walks the stored bytes between execute and end read, one per cycle.
// A new item is accepted only after the previous result is loaded into the output
// register; result loading waits while an unread result is held on the output.
// Reset clears head, count, direction and handshake state; stored bytes are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_byte_deque #(
  parameter int DEPTH = 128
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bbd_pkg::in_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output bbd_pkg::out_t      out_o
);

  bbd_pkg::cmd_t     cmd;
  bbd_pkg::dp_stat_t stat;

  bbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbd_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .out_o (out_o)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for bounded_byte_deque: directed rows, a fill to capacity and
// random operation mixes, each result checked against a typed row or the deque predictor.
// Depends on bbd_pkg and bounded_byte_deque.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 128;
  localparam int RAND_PER_PHASE = 130;
  localparam int SEGMENT_ITEMS = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam int MIX_PUSH_HEAVY = 0;
  localparam int MIX_POP_HEAVY  = 1;
  localparam int MIX_BALANCED   = 2;

  typedef struct packed {
    bbd_pkg::in_t  item;
    logic          typed;
    bbd_pkg::out_t want;
  } dir_row_t;

  localparam bbd_pkg::out_t R_EMPTY_ERR =
    '{bbd_pkg::ST_EMPTY, 1'b0, 8'h00, 8'h00, 8'd0, 1'b1};
  localparam bbd_pkg::out_t R_EMPTY_OK  =
    '{bbd_pkg::ST_OK, 1'b0, 8'h00, 8'h00, 8'd0, 1'b1};
  localparam bbd_pkg::out_t R_NONE      = '0;

  localparam dir_row_t DIRECTED_ROWS [25] = '{
    '{'{bbd_pkg::OP_POP_FRONT, 8'h00}, 1'b1, R_EMPTY_ERR},
    '{'{bbd_pkg::OP_POP_BACK, 8'h7F}, 1'b1, R_EMPTY_ERR},
    '{'{bbd_pkg::OP_REVERSE, 8'h00}, 1'b1, R_EMPTY_ERR},
    '{'{bbd_pkg::OP_SEARCH, 8'h00}, 1'b1, R_EMPTY_ERR},
    '{'{OP_UNUSED_6, 8'hFF}, 1'b1, R_EMPTY_OK},
    '{'{bbd_pkg::OP_PUSH_BACK, 8'hFF}, 1'b1,
      '{bbd_pkg::ST_OK, 1'b0, 8'hFF, 8'hFF, 8'd1, 1'b0}},
    '{'{bbd_pkg::OP_PUSH_FRONT, 8'h00}, 1'b1,
      '{bbd_pkg::ST_OK, 1'b0, 8'h00, 8'hFF, 8'd2, 1'b0}},
    '{'{bbd_pkg::OP_PUSH_BACK, 8'hA5}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_SEARCH, 8'hFF}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_SEARCH, 8'h5A}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_SEARCH, 8'hA5}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_REVERSE, 8'h11}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_PUSH_FRONT, 8'h3C}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_PUSH_BACK, 8'hC3}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_SEARCH, 8'h3C}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_FRONT, 8'h00}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_BACK, 8'h00}, 1'b0, R_NONE},
    '{'{OP_UNUSED_7, 8'h55}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_REVERSE, 8'hEE}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_BACK, 8'h00}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_FRONT, 8'h00}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_FRONT, 8'h00}, 1'b0, R_NONE},
    '{'{bbd_pkg::OP_POP_FRONT, 8'h00}, 1'b1, R_EMPTY_ERR},
    '{'{bbd_pkg::OP_PUSH_FRONT, 8'h80}, 1'b1,
      '{bbd_pkg::ST_OK, 1'b0, 8'h80, 8'h80, 8'd1, 1'b0}},
    '{'{bbd_pkg::OP_POP_BACK, 8'h00}, 1'b1, R_EMPTY_OK}
  };

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  bbd_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  bbd_pkg::out_t out_o;

  logic [7:0]  ring_bytes [DEPTH];
  int unsigned ring_head;
  int unsigned ring_count;
  bit          ring_reversed;

  bbd_pkg::out_t pending_results [$];
  int   snd_idle_pct = 35;
  int   rcv_idle_pct = 76;
  bit   hold_req = 1'b0;
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   full_refusals = 0;
  int   empty_errors = 0;
  int   search_hits = 0;
  int   idle_cycles = 0;

  bounded_byte_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic bbd_pkg::out_t apply_deque_op(input bbd_pkg::in_t item);
    bbd_pkg::out_t r;
    int unsigned   k;
    logic [7:0]    first_b;
    logic [7:0]    last_b;
    r = '0;
    case (item.operation) inside
      bbd_pkg::OP_PUSH_FRONT, bbd_pkg::OP_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = bbd_pkg::ST_FULL;
          full_refusals++;
        end else if ((item.operation == bbd_pkg::OP_PUSH_FRONT) != ring_reversed) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_bytes[ring_head] = item.value;
          ring_count++;
        end else begin
          ring_bytes[(ring_head + ring_count) % DEPTH] = item.value;
          ring_count++;
        end
      end
      bbd_pkg::OP_POP_FRONT, bbd_pkg::OP_POP_BACK, bbd_pkg::OP_REVERSE,
      bbd_pkg::OP_SEARCH: begin
        if (ring_count == 0) begin
          r.status = bbd_pkg::ST_EMPTY;
          empty_errors++;
        end else if (item.operation == bbd_pkg::OP_REVERSE) begin
          ring_reversed = !ring_reversed;
        end else if (item.operation == bbd_pkg::OP_SEARCH) begin
          for (k = 0; k < ring_count; k++) begin
            if (ring_bytes[(ring_head + k) % DEPTH] == item.value) begin
              r.found = 1'b1;
              break;
            end
          end
          if (r.found) search_hits++;
        end else if ((item.operation == bbd_pkg::OP_POP_FRONT) != ring_reversed) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end else begin
          ring_count--;
        end
      end
      default: begin
      end
    endcase
    if (ring_count != 0) begin
      first_b = ring_bytes[ring_head];
      last_b = ring_bytes[(ring_head + ring_count - 1) % DEPTH];
      r.front_byte = ring_reversed ? last_b : first_b;
      r.back_byte = ring_reversed ? first_b : last_b;
    end
    r.length = ring_count[7:0];
    r.is_empty = (ring_count == 0);
    return r;
  endfunction

  task automatic send_item(input bbd_pkg::in_t item, input bit typed,
                           input bbd_pkg::out_t want);
    bbd_pkg::out_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_deque_op(item);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic run_random(input int count);
    int           n;
    int           mix;
    int           push_w;
    int           pop_w;
    int           r;
    bbd_pkg::in_t item;
    mix = MIX_BALANCED;
    for (n = 0; n < count; n++) begin
      if (n % SEGMENT_ITEMS == 0) mix = $urandom_range(MIX_PUSH_HEAVY, MIX_BALANCED);
      case (mix)
        MIX_PUSH_HEAVY: begin push_w = 60; pop_w = 17; end
        MIX_POP_HEAVY:  begin push_w = 17; pop_w = 60; end
        default:        begin push_w = 38; pop_w = 39; end
      endcase
      r = $urandom_range(0, 99);
      item.value = 8'($urandom_range(0, 255));
      if (r < push_w) begin
        item.operation = $urandom_range(0, 1) ? bbd_pkg::OP_PUSH_BACK : bbd_pkg::OP_PUSH_FRONT;
      end else if (r < push_w + pop_w) begin
        item.operation = $urandom_range(0, 1) ? bbd_pkg::OP_POP_BACK : bbd_pkg::OP_POP_FRONT;
      end else if (r < push_w + pop_w + 7) begin
        item.operation = bbd_pkg::OP_REVERSE;
      end else if (r < push_w + pop_w + 20) begin
        item.operation = bbd_pkg::OP_SEARCH;
        if (ring_count != 0 && $urandom_range(0, 1) == 1) begin
          item.value = ring_bytes[(ring_head + $urandom_range(0, ring_count - 1)) % DEPTH];
        end
      end else begin
        item.operation = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
      end
      send_item(item, 1'b0, R_NONE);
    end
  endtask

  task automatic check_result(input bbd_pkg::out_t got);
    bbd_pkg::out_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: result with nothing expected: %p", $realtime, got);
      end
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.front_byte !== want.front_byte || got.back_byte !== want.back_byte ||
          got.length !== want.length || got.is_empty !== want.is_empty) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: mismatch, expected %p, got %p", $realtime, want, got);
        end
      end
    end
  endtask

  initial begin : result_side
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result(out_o);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", pending_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int           i;
    bbd_pkg::in_t item;
    ring_head = 0;
    ring_count = 0;
    ring_reversed = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    for (i = 0; i < DEPTH + 3; i++) begin
      item.operation = (i % 2 == 0) ? bbd_pkg::OP_PUSH_BACK : bbd_pkg::OP_PUSH_FRONT;
      item.value = 8'($urandom_range(0, 255));
      send_item(item, 1'b0, R_NONE);
    end
    item.operation = bbd_pkg::OP_SEARCH;
    send_item(item, 1'b0, R_NONE);
    item.operation = bbd_pkg::OP_REVERSE;
    send_item(item, 1'b0, R_NONE);
    item.operation = bbd_pkg::OP_PUSH_FRONT;
    send_item(item, 1'b0, R_NONE);

    run_random(RAND_PER_PHASE);
    snd_idle_pct = 76;
    rcv_idle_pct = 35;
    run_random(RAND_PER_PHASE);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(RAND_PER_PHASE);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items and checked %0d results, %0d mismatches.",
             items_sent, results_checked, mismatch_count);
    $display("Covered %0d full pushes, %0d empty-store errors and %0d search hits.",
             full_refusals, empty_errors, search_hits);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
